// File: sv/cvt_pkg.sv
package cvt_pkg;

	// default sizing, used as the parameter defaults of the top level
	localparam int CACHE_ENTRIES_DEF = 1024;
	localparam int FRAC_BITS_DEF     = 16;

	// fixed field widths
	localparam int IDX_W    = 10;
	localparam int VAL_W    = 32;
	localparam int VP_W     = 13;
	localparam int PROD_W   = VP_W + 1 + VAL_W + 1;
	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 96;
	localparam int OUT_TUSER_W = 2;
	localparam int STORE_W  = 3 * VAL_W + 1;

	// register indexes
	localparam logic REG_VP_WIDTH  = 1'b0;
	localparam logic REG_VP_HEIGHT = 1'b1;

	// item kinds on the input tuser
	localparam logic FUNC_TRANSFORM = 1'b0;
	localparam logic FUNC_CLEAR     = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_CHECK,
		ST_DIVIDE,
		ST_MAP1,
		ST_MAP2,
		ST_DONE
	} cvt_state_t;

	typedef struct packed {
		logic capture;
		logic clr_step;
		logic div_start;
		logic map1;
		logic map2;
		logic out_load;
		logic sel_hit;
		logic store_we;
	} cvt_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic hit;
		logic w_zero;
	} cvt_sts_t;

	// saturate a widened signed value to 32 bits
	function automatic logic [VAL_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		begin
			hi = PROD_W'(64'sh7FFF_FFFF);
			lo = -PROD_W'(64'sh8000_0000);
			if (v > hi)
				sat_prod = 32'h7FFF_FFFF;
			else if (v < lo)
				sat_prod = 32'h8000_0000;
			else
				sat_prod = v[VAL_W-1:0];
		end
	endfunction

endpackage

// File: sv/cached_viewport_transform.sv
// Cached perspective divide and viewport transform. A transform word looks up
// its vertex index in the cache: a hit returns the stored window position; a
// miss runs the three divides by w in parallel on bit-serial dividers, then
// maps the quotients to the viewport and offers the result. A zero w skips the
// divide. One word is in work at a time. A clear word, and reset, sweep the
// mark bits one entry a cycle, during which no input is taken. Positions keep
// the viewport they were computed with until the next clear.
module cached_viewport_transform #(
	parameter int CACHE_ENTRIES = cvt_pkg::CACHE_ENTRIES_DEF,
	parameter int FRAC_BITS     = cvt_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// vertex_index, clip_x, clip_y, clip_z, clip_w, zero pad
	input  logic [cvt_pkg::IN_TDATA_W-1:0]  s_tdata,
	// func
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// win_x, win_y, win_z
	output logic [cvt_pkg::OUT_TDATA_W-1:0] m_tdata,
	// cache_hit, w_was_zero
	output logic [cvt_pkg::OUT_TUSER_W-1:0] m_tuser,
	input  logic                            cfg_we,
	input  logic                            cfg_addr,
	input  logic [cvt_pkg::VP_W-1:0]        cfg_wdata
);
	import cvt_pkg::*;

	cvt_cmd_t cmd;
	cvt_sts_t sts;

	cvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	cvt_dp #(
		.CACHE_ENTRIES (CACHE_ENTRIES),
		.FRAC_BITS     (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// File: sv/cvt_ram.sv
module cvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/cvt_div.sv
module cvt_div #(
	parameter int FRAC_BITS = cvt_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);
	import cvt_pkg::*;

	localparam int NW = VAL_W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam logic [NW-1:0] LIM_POS = NW'(64'h7FFF_FFFF);
	localparam logic [NW-1:0] LIM_NEG = NW'(64'h8000_0000);

	logic [31:0]   rem_q;
	logic [NW-1:0] dvd_q;
	logic [31:0]   dmag_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;

	logic [31:0] num_mag;
	logic [31:0] den_mag;
	logic [32:0] shl;
	logic [32:0] diff;
	logic        ge;

	assign num_mag = num[31] ? (~num + 32'd1) : num;
	assign den_mag = den[31] ? (~den + 32'd1) : den;
	assign shl     = {rem_q, dvd_q[NW-1]};
	assign diff    = shl - {1'b0, dmag_q};
	assign ge      = ~diff[32];

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvd_q  <= {num_mag, {FRAC_BITS{1'b0}}};
			dmag_q <= den_mag;
			neg_q  <= num[31] ^ den[31];
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : shl[31:0];
			dvd_q <= {dvd_q[NW-2:0], ge};
		end
	end

	// apply sign and saturate the magnitude
	always_comb begin
		if (!neg_q)
			quo = (dvd_q > LIM_POS) ? 32'h7FFF_FFFF : dvd_q[31:0];
		else
			quo = (dvd_q > LIM_NEG) ? 32'h8000_0000 : (~dvd_q[31:0] + 32'd1);
	end

	assign done = done_q;

endmodule

// File: sv/cvt_ctrl.sv
module cvt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tuser,
	output logic              s_tready,
	input  logic              m_tready,
	output logic              m_tvalid,
	input  cvt_pkg::cvt_sts_t sts,
	output cvt_pkg::cvt_cmd_t cmd
);
	import cvt_pkg::*;

	cvt_state_t state_q;
	cvt_state_t state_d;
	logic       hit_q;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = ~m_tvalid_q | m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (s_tvalid)
					state_d = (s_tuser == FUNC_CLEAR) ? ST_CLEAR : ST_LOOKUP;
			end
			ST_LOOKUP: state_d = ST_CHECK;
			ST_CHECK: begin
				if (sts.hit)
					state_d = ST_DONE;
				else if (sts.w_zero)
					state_d = ST_MAP1;
				else
					state_d = ST_DIVIDE;
			end
			ST_DIVIDE: if (sts.div_done) state_d = ST_MAP1;
			ST_MAP1:   state_d = ST_MAP2;
			ST_MAP2:   state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_CHECK:  cmd.div_start = ~sts.hit & ~sts.w_zero;
			ST_MAP1:   cmd.map1 = 1'b1;
			ST_MAP2:   cmd.map2 = 1'b1;
			ST_DONE: begin
				cmd.out_load = out_free;
				cmd.sel_hit  = hit_q;
				cmd.store_we = out_free & ~hit_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			hit_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK)
				hit_q <= sts.hit;
			// hold the result word until taken
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// File: sv/cvt_dp.sv
module cvt_dp #(
	parameter int CACHE_ENTRIES = cvt_pkg::CACHE_ENTRIES_DEF,
	parameter int FRAC_BITS     = cvt_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cvt_pkg::cvt_cmd_t               cmd,
	output cvt_pkg::cvt_sts_t               sts,
	input  logic [cvt_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            cfg_we,
	input  logic                            cfg_addr,
	input  logic [cvt_pkg::VP_W-1:0]        cfg_wdata,
	output logic [cvt_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [cvt_pkg::OUT_TUSER_W-1:0] m_tuser
);
	import cvt_pkg::*;

	localparam int AW = $clog2(CACHE_ENTRIES);
	localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

	logic [VP_W-1:0]  vp_w_q;
	logic [VP_W-1:0]  vp_h_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      x_q, y_q, z_q, w_q;
	logic [AW-1:0]    clr_cnt_q;

	logic [31:0]   idx32;
	logic [AW-1:0] addr;
	logic          cacheable;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [STORE_W-1:0] ram_wdata;
	logic [STORE_W-1:0] ram_rdata;

	logic [31:0] qx, qy, qz;
	logic        dx, dy, dz;

	logic signed [31:0]     xs, ys, zs;
	logic signed [PROD_W-1:0] px_s1, py_s1;
	logic signed [32:0]     sz_s1;
	logic [31:0]            wx_s2, wy_s2, wz_s2;
	logic signed [PROD_W-1:0] hx, hy;

	logic [OUT_TDATA_W-1:0] res_q;
	logic [OUT_TUSER_W-1:0] flags_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_w_q <= VP_W'(640);
			vp_h_q <= VP_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_VP_WIDTH:  vp_w_q <= cfg_wdata;
				REG_VP_HEIGHT: vp_h_q <= cfg_wdata;
			endcase
		end
	end

	// capture the input word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= s_tdata[9:0];
			x_q   <= s_tdata[41:10];
			y_q   <= s_tdata[73:42];
			z_q   <= s_tdata[105:74];
			w_q   <= s_tdata[137:106];
		end
	end

	assign idx32     = 32'(idx_q);
	assign addr      = idx32[AW-1:0];
	assign cacheable = idx32 < 32'(CACHE_ENTRIES);

	// sweep the mark bits after reset and on a clear word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_step)
			clr_cnt_q <= sts.clr_last ? '0 : clr_cnt_q + 1'b1;
	end

	assign ram_we    = cmd.clr_step | (cmd.store_we & cacheable);
	assign ram_waddr = cmd.clr_step ? clr_cnt_q : addr;
	assign ram_wdata = cmd.clr_step ? '0 : {1'b1, wz_s2, wy_s2, wx_s2};

	cvt_ram #(
		.WIDTH (STORE_W),
		.DEPTH (CACHE_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// three divider lanes run side by side
	cvt_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(x_q), .den(w_q), .done(dx), .quo(qx)
	);
	cvt_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(y_q), .den(w_q), .done(dy), .quo(qy)
	);
	cvt_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(z_q), .den(w_q), .done(dz), .quo(qz)
	);

	assign sts.clr_last = (clr_cnt_q == AW'(CACHE_ENTRIES - 1));
	assign sts.div_done = dx & dy & dz;
	assign sts.hit      = cacheable & ram_rdata[STORE_W-1];
	assign sts.w_zero   = (w_q == 32'd0);

	// skip the divide when w is zero
	assign xs = sts.w_zero ? x_q : qx;
	assign ys = sts.w_zero ? y_q : qy;
	assign zs = sts.w_zero ? z_q : qz;

	// viewport products
	always_ff @(posedge clk) begin
		if (cmd.map1) begin
			px_s1 <= $signed({1'b0, vp_w_q}) * (33'(xs) + ONE);
			py_s1 <= $signed({1'b0, vp_h_q}) * (ONE - 33'(ys));
			sz_s1 <= 33'(zs) + ONE;
		end
	end

	// halve with floor, then saturate
	assign hx = px_s1 >>> 1;
	assign hy = py_s1 >>> 1;

	always_ff @(posedge clk) begin
		if (cmd.map2) begin
			wx_s2 <= sat_prod(hx);
			wy_s2 <= sat_prod(hy);
			wz_s2 <= sz_s1[32:1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.sel_hit) begin
				res_q   <= ram_rdata[OUT_TDATA_W-1:0];
				flags_q <= 2'b01;
			end else begin
				res_q   <= {wz_s2, wy_s2, wx_s2};
				flags_q <= {sts.w_zero, 1'b0};
			end
		end
	end

	assign m_tdata = res_q;
	assign m_tuser = flags_q;

endmodule

// File: sv/cvt_checker.sv
module cvt_props (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [1:0] m_tuser
);
	import cvt_pkg::*;

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// a cached position never reports a skipped divide
	a_hit_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1])
		else $error("hit word flags w zero");

	// a clear word starts the sweep and blocks input
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == FUNC_CLEAR |=> !s_tready)
		else $error("input taken during mark sweep");

	// a transform word is worked on alone
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == FUNC_TRANSFORM |=> !s_tready)
		else $error("input taken while a word is in work");

endmodule

bind cached_viewport_transform cvt_props u_cvt_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser)
);

// File: tb/cvt_checker.sv
`timescale 1ns / 100ps

module cvt_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [cvt_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [cvt_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic [cvt_pkg::OUT_TUSER_W-1:0] m_tuser,
	input  logic                            cfg_we,
	input  logic                            cfg_addr,
	input  logic [cvt_pkg::VP_W-1:0]        cfg_wdata,
	output int                              pending,
	output int                              errors
);
	import cvt_pkg::*;

	localparam longint ONE = longint'(1) << FRAC_BITS_DEF;

	typedef struct packed {
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] z;
		logic             hit;
		logic             wzero;
	} win_pos_t;

	win_pos_t         win_q[$];
	logic [VP_W-1:0]  vp_width;
	logic [VP_W-1:0]  vp_height;
	logic             marked[CACHE_ENTRIES_DEF];
	win_pos_t         stored[CACHE_ENTRIES_DEF];

	assign pending = win_q.size();

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// truncating divide in Q16.16, saturated
	function automatic longint persp_div(input longint v, input longint w);
		return clamp32((v * ONE) / w);
	endfunction

	function automatic win_pos_t map_vertex(input logic [IN_TDATA_W-1:0] d);
		longint   cx, cy, cz, cw;
		win_pos_t r;
		cx = longint'($signed(d[41:10]));
		cy = longint'($signed(d[73:42]));
		cz = longint'($signed(d[105:74]));
		cw = longint'($signed(d[137:106]));
		r.hit   = 1'b0;
		r.wzero = (cw == 0);
		if (cw != 0) begin
			cx = persp_div(cx, cw);
			cy = persp_div(cy, cw);
			cz = persp_div(cz, cw);
		end
		r.x = VAL_W'(clamp32((longint'(vp_width) * (cx + ONE)) >>> 1));
		r.y = VAL_W'(clamp32((longint'(vp_height) * (ONE - cy)) >>> 1));
		r.z = VAL_W'(clamp32((cz + ONE) >>> 1));
		return r;
	endfunction

	// predict on accepted input words, compare accepted output words
	always @(posedge clk or negedge arst_n) begin
		win_pos_t        e;
		logic [IDX_W-1:0] idx;
		if (!arst_n) begin
			vp_width  <= VP_W'(640);
			vp_height <= VP_W'(480);
			for (int i = 0; i < CACHE_ENTRIES_DEF; i++)
				marked[i] = 1'b0;
			win_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_VP_WIDTH)
					vp_width <= cfg_wdata;
				else
					vp_height <= cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				idx = s_tdata[IDX_W-1:0];
				if (s_tuser == FUNC_CLEAR) begin
					for (int i = 0; i < CACHE_ENTRIES_DEF; i++)
						marked[i] = 1'b0;
				end else if (marked[idx]) begin
					e = stored[idx];
					e.hit = 1'b1;
					e.wzero = 1'b0;
					win_q = {win_q, e};
				end else begin
					e = map_vertex(s_tdata);
					stored[idx] = e;
					marked[idx] = 1'b1;
					win_q = {win_q, e};
				end
			end
			if (m_tvalid && m_tready) begin
				if (win_q.size() == 0) begin
					$error("unexpected output word %h user %b", m_tdata, m_tuser);
					errors++;
				end else begin
					e = win_q.pop_front();
					if (m_tdata[31:0] !== e.x) begin
						$error("win_x expected %h actual %h", e.x, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[63:32] !== e.y) begin
						$error("win_y expected %h actual %h", e.y, m_tdata[63:32]);
						errors++;
					end
					if (m_tdata[95:64] !== e.z) begin
						$error("win_z expected %h actual %h", e.z, m_tdata[95:64]);
						errors++;
					end
					if (m_tuser[0] !== e.hit) begin
						$error("cache_hit expected %b actual %b", e.hit, m_tuser[0]);
						errors++;
					end
					if (m_tuser[1] !== e.wzero) begin
						$error("w_was_zero expected %b actual %b", e.wzero, m_tuser[1]);
						errors++;
					end
				end
			end
		end
	end

endmodule

// File: tb/tb_cached_viewport_transform.sv
`timescale 1ns / 100ps

module tb_cached_viewport_transform;
	import cvt_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE      = 1200;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   cfg_we;
	logic                   cfg_addr;
	logic [VP_W-1:0]        cfg_wdata;
	int                     pending;
	int                     errors;
	int                     cycles;
	int                     burst_left;
	int                     stall_mode;

	cached_viewport_transform i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	cvt_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.errors    (errors)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stall the output side: stretches of always ready, then random patterns
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ~m_tready;
		endcase
	end

	// drive one word, pausing between bursts
	task automatic send_word(input logic fn, input logic [IDX_W-1:0] idx,
			input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] w);
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		s_tdata  <= {6'b0, w, z, y, x, idx};
		s_tuser  <= fn;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// hold off until every result is back and a clear sweep can finish
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [VP_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_edge();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return Q_ONE;
			default: return -Q_ONE;
		endcase
	endfunction

	task automatic random_words(input int count);
		logic [IDX_W-1:0] idx;
		logic [31:0]      x, y, z, w;
		int               kind;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 2) begin
				send_word(FUNC_CLEAR, IDX_W'($urandom), $urandom, $urandom, $urandom,
					$urandom);
				continue;
			end
			idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) :
				IDX_W'($urandom_range(0, 15));
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				x = $urandom; y = $urandom; z = $urandom; w = $urandom;
			end else if (kind < 8) begin
				x = $urandom_range(0, 16 * 65536) - 8 * 65536;
				y = $urandom_range(0, 16 * 65536) - 8 * 65536;
				z = $urandom_range(0, 16 * 65536) - 8 * 65536;
				w = $urandom_range(0, 8 * 65536) - 4 * 65536;
			end else if (kind == 8) begin
				x = $urandom; y = $urandom; z = $urandom; w = 32'h0;
			end else begin
				x = pick_edge(); y = pick_edge(); z = pick_edge(); w = pick_edge();
			end
			send_word(FUNC_TRANSFORM, idx, x, y, z, w);
			// once, let every result come back before going on
			if (n == count / 2 && count > 200) begin
				s_tvalid <= 1'b0;
				burst_left = 0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = FUNC_TRANSFORM;
		m_tready   = 1'b0;
		cfg_we     = 1'b0;
		cfg_addr   = REG_VP_WIDTH;
		cfg_wdata  = '0;
		cycles     = 0;
		burst_left = 0;
		stall_mode = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero w, hits, out-of-range quotients, clear
		send_word(FUNC_TRANSFORM, 10'd0, 32'h0, 32'h0, 32'h0, Q_ONE);
		send_word(FUNC_TRANSFORM, 10'd0, 32'h1234, 32'h5678, 32'h9ABC, Q_ONE);
		send_word(FUNC_TRANSFORM, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h1);
		send_word(FUNC_TRANSFORM, 10'd1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF);
		send_word(FUNC_TRANSFORM, 10'd2, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		send_word(FUNC_TRANSFORM, 10'd3, Q_ONE, -Q_ONE, 32'h0, 32'h0);
		send_word(FUNC_TRANSFORM, 10'd4, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h0);
		send_word(FUNC_TRANSFORM, 10'd3, 32'h5, 32'h5, 32'h5, Q_ONE);
		send_word(FUNC_TRANSFORM, 10'd5, 32'h0003_0000, 32'hFFFD_0000,
			32'h0001_8000, 32'h0002_0000);
		send_word(FUNC_TRANSFORM, 10'd6, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF,
			32'h7FFF_FFFF);
		send_word(FUNC_TRANSFORM, 10'd1023, 32'h0, 32'h0, 32'h0, Q_ONE);
		send_word(FUNC_CLEAR, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(FUNC_TRANSFORM, 10'd0, 32'h0000_8000, 32'hFFFF_8000,
			32'h0, Q_ONE);
		send_word(FUNC_TRANSFORM, 10'd1023, 32'h0, 32'h0, 32'h0, 32'h0);
		send_word(FUNC_TRANSFORM, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0);
		drain();

		// stored positions keep the old viewport until a clear
		write_reg(REG_VP_WIDTH, VP_W'(1));
		write_reg(REG_VP_HEIGHT, VP_W'(1));
		send_word(FUNC_TRANSFORM, 10'd0, 32'h0, 32'h0, 32'h0, Q_ONE);
		random_words(240);
		drain();

		write_reg(REG_VP_WIDTH, VP_W'(4096));
		write_reg(REG_VP_HEIGHT, VP_W'(4096));
		random_words(240);
		drain();

		write_reg(REG_VP_WIDTH, VP_W'(8191));
		write_reg(REG_VP_HEIGHT, VP_W'(0));
		random_words(240);
		drain();

		write_reg(REG_VP_WIDTH, VP_W'(0));
		write_reg(REG_VP_HEIGHT, VP_W'(8191));
		random_words(200);
		drain();

		write_reg(REG_VP_WIDTH, VP_W'($urandom_range(1, 4096)));
		write_reg(REG_VP_HEIGHT, VP_W'($urandom_range(1, 4096)));
		random_words(300);
		drain();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
